>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the distance range qualifier.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

>>> src/meq_pkg.sv
// Package for the median/EMA range qualifier: register indexes, status codes,
// reset values and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package meq_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ON    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMA_TAU      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_RUN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE      = 3'd7;

    localparam logic [1:0] STAT_NO_DATA = 2'd0;
    localparam logic [1:0] STAT_STALE   = 2'd1;
    localparam logic [1:0] STAT_FAIL    = 2'd2;
    localparam logic [1:0] STAT_PASS    = 2'd3;

    localparam logic [3:0]  RST_WINDOW_LEN = 4'd3;
    localparam logic [31:0] RST_EMA_TAU    = 32'd100000;
    localparam logic [31:0] RST_SCALE      = 32'd16777;
    localparam logic [7:0]  RST_REQ_RUN    = 8'd3;
    localparam logic [31:0] RST_MAX_AGE    = 32'd500000;

    localparam int DIV_STEPS = 20;
    localparam int SQ_STEPS  = 12;

    typedef enum logic [19:0] {
        S_IDLE      = 20'h00001,
        S_PUSH      = 20'h00002,
        S_LOAD      = 20'h00004,
        S_MED_LO    = 20'h00008,
        S_MED_HI    = 20'h00010,
        S_EMA       = 20'h00020,
        S_DIV       = 20'h00040,
        S_POLY1     = 20'h00080,
        S_POLY2     = 20'h00100,
        S_POLY3     = 20'h00200,
        S_SQ        = 20'h00400,
        S_SQ_ACC    = 20'h00800,
        S_ALPHA     = 20'h01000,
        S_UPD_MUL   = 20'h02000,
        S_UPD       = 20'h04000,
        S_TICK      = 20'h08000,
        S_SCALE_MUL = 20'h10000,
        S_SCALE     = 20'h20000,
        S_SCALE_CMP = 20'h40000,
        S_OUT       = 20'h80000
    } state_t;

endpackage

>>> src/median_ema_range_qualifier_top.sv
// Top level of the median/EMA distance range qualifier with its sequencer.
// Depends on meq_pkg and assert_macros.svh.
//
// Channel    Side    Handshake                  Payload
// s_axis     in      s_axis_tvalid/tready       tdata, tuser
// m_axis     out     m_axis_tvalid/tready       tdata, tuser
// cfg        in      cfg_valid/cfg_ready        cfg_index, cfg_data
//
// An invalid sample, or any sample with filtering off, stays in S_IDLE.
// A filtered sample steps through window load, median, and when needed
// the serial divider and twelve squarings on the one shared multiplier;
// no sample is taken until the sequencer is idle. A tick waits in S_OUT
// for the output register. Reset clears the control state at once; no
// clearing pass is needed. The configuration port is always ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module median_ema_range_qualifier_top
    import meq_pkg::*;
#(
    parameter int MAX_WINDOW  = 8,
    parameter int SAMPLE_BITS = 24,
    parameter int RUN_MAX     = 255
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sample_value, now_time, zero padding
    input  logic [((SAMPLE_BITS + 39) / 8) * 8 - 1:0] s_axis_tdata,
    // operation, sample_invalid
    input  logic [1:0]                             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // run length, scaled value, sample age
    output logic [71:0]                            m_axis_tdata,
    // pressed, status
    output logic [2:0]                             m_axis_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]                   cfg_index,
    input  logic [31:0]                            cfg_data
);

    localparam int SW   = SAMPLE_BITS;
    localparam int FRAC = 32 - SAMPLE_BITS;
    localparam int IW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FW   = $clog2(MAX_WINDOW + 1);
    localparam int RW   = $clog2(RUN_MAX + 1);
    localparam logic signed [65:0] SC_RND = 66'sd1 <<< (FRAC + 7);
    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    state_t state_reg, state_next;

    logic signed [SW-1:0] win_reg [MAX_WINDOW];
    logic signed [SW-1:0] win_next [MAX_WINDOW];
    logic signed [SW-1:0] sorted_reg [MAX_WINDOW];
    logic signed [SW-1:0] sorted_next [MAX_WINDOW];
    logic signed [SW-1:0] sorted_ins [MAX_WINDOW];

    logic [FW-1:0]  fill_reg, fill_next;
    logic [IW-1:0]  oldest_reg, oldest_next;
    logic [IW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]  sort_cnt_reg, sort_cnt_next;
    logic signed [31:0] smooth_reg, smooth_next;
    logic           started_reg, started_next;
    logic [31:0]    last_stamp_reg, last_stamp_next;
    logic signed [31:0] latest_reg, latest_next;
    logic           latest_bad_reg, latest_bad_next;
    logic [31:0]    latest_stamp_reg, latest_stamp_next;
    logic           have_reg, have_next;
    logic [RW-1:0]  pass_run_reg, pass_run_next;

    logic           filter_on_reg, filter_on_next;
    logic [3:0]     window_len_reg, window_len_next;
    logic [31:0]    tau_reg, tau_next;
    logic [31:0]    scale_reg, scale_next;
    logic signed [31:0] target_reg, target_next;
    logic [30:0]    tol_reg, tol_next;
    logic [7:0]     req_reg, req_next;
    logic [31:0]    max_age_reg, max_age_next;

    logic signed [SW-1:0] samp_reg, samp_next;
    logic [31:0]    stamp_reg, stamp_next;
    logic signed [SW-1:0] med_a_reg, med_a_next;
    logic signed [31:0] med_reg, med_next;
    logic [4:0]     iter_reg, iter_next;
    logic [31:0]    rem_reg, rem_next;
    logic [19:0]    dbits_reg, dbits_next;
    logic [19:0]    q_reg, q_next;
    logic [15:0]    y2_reg, y2_next;
    logic [31:0]    e_reg, e_next;
    logic [16:0]    alpha_reg, alpha_next;
    logic signed [65:0] mul_reg, mul_next;
    logic signed [65:0] scaled_reg, scaled_next;
    logic [1:0]     res_status_reg, res_status_next;
    logic [31:0]    res_scaled_reg, res_scaled_next;
    logic [31:0]    res_age_reg, res_age_next;

    logic           out_valid_reg, out_valid_next;
    logic           out_pressed_reg, out_pressed_next;
    logic [1:0]     out_status_reg, out_status_next;
    logic [7:0]     out_run_reg, out_run_next;
    logic [31:0]    out_scaled_reg, out_scaled_next;
    logic [31:0]    out_age_reg, out_age_next;

    logic           in_acc;
    logic signed [SW-1:0] raw_in;
    logic [FW-1:0]  len_eff;
    logic [IW-1:0]  oldest_pk;
    logic [FW-1:0]  fill_pk;
    logic [IW-1:0]  wr_idx;
    logic signed [SW-1:0] t_val;
    logic [IW-1:0]  med_idx;
    logic signed [SW-1:0] med_rd;
    logic signed [SW:0] msum;
    logic signed [32:0] m33;
    logic signed [31:0] m32;
    logic [31:0]    dt;
    logic           dt_pos;
    logic           dt_big;
    logic [32:0]    trial;
    logic           trial_ge;
    logic signed [32:0] mul_a, mul_b;
    logic signed [32:0] diff;
    logic [7:0]     y3;
    logic [15:0]    y3_prod;
    logic [32:0]    e33;
    logic [62:0]    sq63;
    logic [32:0]    d33;
    logic [17:0]    a18;
    logic signed [65:0] upd;
    logic [31:0]    age;
    logic signed [65:0] lo_v, hi_v;
    logic [7:0]     req_eff;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [FW-1:0] b);
        logic [FW:0] s;
        s = (FW + 1)'(a) + (FW + 1)'(b);
        if (s >= (FW + 1)'(MAX_WINDOW)) begin
            s = s - (FW + 1)'(MAX_WINDOW);
        end
        return IW'(s);
    endfunction

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign raw_in        = $signed(s_axis_tdata[SW-1:0]);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_age_reg, out_scaled_reg, out_run_reg};
    assign m_axis_tuser  = {out_status_reg, out_pressed_reg};

    always_comb
    begin
        if (window_len_reg == 4'd0) begin
            len_eff = FW'(1);
        end else if (32'(window_len_reg) > 32'(MAX_WINDOW)) begin
            len_eff = FW'(MAX_WINDOW);
        end else begin
            len_eff = FW'(window_len_reg);
        end
        if (fill_reg >= len_eff) begin
            oldest_pk = wrap_add(oldest_reg, fill_reg - len_eff + FW'(1));
            fill_pk   = len_eff - FW'(1);
        end else begin
            oldest_pk = oldest_reg;
            fill_pk   = fill_reg;
        end
        wr_idx = wrap_add(oldest_pk, fill_pk);
    end

    assign t_val = win_reg[rd_ptr_reg];

    always_comb
    begin
        sorted_ins[0] = (sort_cnt_reg != FW'(0) && sorted_reg[0] <= t_val) ? sorted_reg[0] : t_val;
        for (int k = 1; k < MAX_WINDOW; k++) begin
            if (FW'(k) < sort_cnt_reg && sorted_reg[k] <= t_val) begin
                sorted_ins[k] = sorted_reg[k];
            end else if (FW'(k) <= sort_cnt_reg && sorted_reg[k - 1] <= t_val) begin
                sorted_ins[k] = t_val;
            end else if (FW'(k) <= sort_cnt_reg) begin
                sorted_ins[k] = sorted_reg[k - 1];
            end else begin
                sorted_ins[k] = sorted_reg[k];
            end
        end
    end

    assign med_idx = (state_reg == S_MED_LO && !fill_reg[0]) ? IW'((fill_reg >> 1) - FW'(1))
                                                             : IW'(fill_reg >> 1);
    assign med_rd  = sorted_reg[med_idx];

    always_comb
    begin
        msum = {med_a_reg[SW-1], med_a_reg} + {med_rd[SW-1], med_rd};
        m33  = 33'(msum);
        m33  = m33 <<< FRAC;
        m33  = m33 >>> 1;
        m32  = 32'(med_a_reg);
        m32  = m32 <<< FRAC;
    end

    assign dt       = stamp_reg - last_stamp_reg;
    assign dt_pos   = !dt[31] && (dt != 32'd0);
    assign dt_big   = {4'b0, dt} >= {tau_reg, 4'b0};
    assign trial    = {rem_reg, dbits_reg[19]};
    assign trial_ge = trial >= {1'b0, tau_reg};
    assign diff     = 33'(med_reg) - 33'(smooth_reg);
    assign y3       = mul_reg[38:31];
    assign y3_prod  = 16'(y3) * 16'd171;
    assign e33      = 33'h080000000 - 33'({q_reg, 3'b0}) + 33'(y2_reg[15:1])
                      - 33'(y3_prod[15:10]);
    assign sq63     = mul_reg[62:0] + 63'h40000000;
    assign d33      = 33'h080000000 - 33'(e_reg) + 33'h4000;
    assign a18      = d33[32:15];
    assign upd      = (mul_reg + 66'sd32768) >>> 16;
    assign age      = stamp_reg - latest_stamp_reg;
    assign lo_v     = 66'(target_reg) - $signed(66'(tol_reg));
    assign hi_v     = 66'(target_reg) + $signed(66'(tol_reg));
    assign req_eff  = (req_reg == 8'd0) ? 8'd1 : req_reg;

    always_comb
    begin
        case (state_reg)
            S_POLY1:
            begin
                mul_a = $signed({10'b0, q_reg, 3'b0});
                mul_b = $signed({10'b0, q_reg, 3'b0});
            end
            S_POLY2:
            begin
                mul_a = $signed({17'b0, mul_reg[46:31]});
                mul_b = $signed({10'b0, q_reg, 3'b0});
            end
            S_SQ:
            begin
                mul_a = $signed({1'b0, e_reg});
                mul_b = $signed({1'b0, e_reg});
            end
            S_UPD_MUL:
            begin
                mul_a = diff;
                mul_b = $signed({16'b0, alpha_reg});
            end
            S_SCALE_MUL:
            begin
                mul_a = 33'(latest_reg);
                mul_b = $signed({1'b0, scale_reg});
            end
            default:
            begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    assign mul_next = mul_a * mul_b;

    always_comb
    begin
        state_next        = state_reg;
        win_next          = win_reg;
        sorted_next       = sorted_reg;
        fill_next         = fill_reg;
        oldest_next       = oldest_reg;
        rd_ptr_next       = rd_ptr_reg;
        sort_cnt_next     = sort_cnt_reg;
        smooth_next       = smooth_reg;
        started_next      = started_reg;
        last_stamp_next   = last_stamp_reg;
        latest_next       = latest_reg;
        latest_bad_next   = latest_bad_reg;
        latest_stamp_next = latest_stamp_reg;
        have_next         = have_reg;
        pass_run_next     = pass_run_reg;
        filter_on_next    = filter_on_reg;
        window_len_next   = window_len_reg;
        tau_next          = tau_reg;
        scale_next        = scale_reg;
        target_next       = target_reg;
        tol_next          = tol_reg;
        req_next          = req_reg;
        max_age_next      = max_age_reg;
        samp_next         = samp_reg;
        stamp_next        = stamp_reg;
        med_a_next        = med_a_reg;
        med_next          = med_reg;
        iter_next         = iter_reg;
        rem_next          = rem_reg;
        dbits_next        = dbits_reg;
        q_next            = q_reg;
        y2_next           = y2_reg;
        e_next            = e_reg;
        alpha_next        = alpha_reg;
        scaled_next       = scaled_reg;
        res_status_next   = res_status_reg;
        res_scaled_next   = res_scaled_reg;
        res_age_next      = res_age_reg;
        out_valid_next    = out_valid_reg;
        out_pressed_next  = out_pressed_reg;
        out_status_next   = out_status_reg;
        out_run_next      = out_run_reg;
        out_scaled_next   = out_scaled_reg;
        out_age_next      = out_age_reg;

        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                REG_FILTER_ON:    filter_on_next  = cfg_data[0];
                REG_WINDOW_LEN:   window_len_next = cfg_data[3:0];
                REG_EMA_TAU:      tau_next        = cfg_data;
                REG_SCALE:        scale_next      = cfg_data;
                REG_TARGET:       target_next     = $signed(cfg_data);
                REG_TOLERANCE:    tol_next        = cfg_data[30:0];
                REG_REQUIRED_RUN: req_next        = cfg_data[7:0];
                REG_MAX_AGE:      max_age_next    = cfg_data;
                default:          filter_on_next  = filter_on_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc) begin
                    samp_next  = raw_in;
                    stamp_next = s_axis_tdata[SW+31:SW];
                    if (s_axis_tuser[0]) begin
                        state_next = S_TICK;
                    end else begin
                        latest_stamp_next = s_axis_tdata[SW+31:SW];
                        have_next         = 1'b1;
                        if (s_axis_tuser[1]) begin
                            latest_bad_next = 1'b1;
                        end else begin
                            latest_bad_next = 1'b0;
                            if (filter_on_reg) begin
                                state_next = S_PUSH;
                            end else begin
                                latest_next = 32'(raw_in) <<< FRAC;
                            end
                        end
                    end
                end
            end
            S_PUSH:
            begin
                oldest_next      = oldest_pk;
                fill_next        = fill_pk + FW'(1);
                win_next[wr_idx] = samp_reg;
                rd_ptr_next      = oldest_pk;
                sort_cnt_next    = FW'(0);
                state_next       = S_LOAD;
            end
            S_LOAD:
            begin
                sorted_next   = sorted_ins;
                sort_cnt_next = sort_cnt_reg + FW'(1);
                rd_ptr_next   = wrap_add(rd_ptr_reg, FW'(1));
                if (sort_cnt_reg + FW'(1) == fill_reg) begin
                    state_next = S_MED_LO;
                end
            end
            S_MED_LO:
            begin
                med_a_next = med_rd;
                state_next = S_MED_HI;
            end
            S_MED_HI:
            begin
                med_next   = fill_reg[0] ? m32 : m33[31:0];
                state_next = S_EMA;
            end
            S_EMA:
            begin
                last_stamp_next = stamp_reg;
                if (tau_reg == 32'd0 || !started_reg) begin
                    smooth_next  = med_reg;
                    started_next = 1'b1;
                    latest_next  = med_reg;
                    state_next   = S_IDLE;
                end else if (!dt_pos) begin
                    latest_next = smooth_reg;
                    state_next  = S_IDLE;
                end else if (dt_big) begin
                    alpha_next = 17'h10000;
                    state_next = S_UPD_MUL;
                end else begin
                    rem_next   = {4'b0, dt[31:4]};
                    dbits_next = {dt[3:0], 16'b0};
                    q_next     = 20'd0;
                    iter_next  = 5'(DIV_STEPS);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next   = trial_ge ? 32'(trial - {1'b0, tau_reg}) : trial[31:0];
                q_next     = {q_reg[18:0], trial_ge};
                dbits_next = {dbits_reg[18:0], 1'b0};
                iter_next  = iter_reg - 5'd1;
                if (iter_reg == 5'd1) begin
                    state_next = S_POLY1;
                end
            end
            S_POLY1:
            begin
                state_next = S_POLY2;
            end
            S_POLY2:
            begin
                y2_next    = mul_reg[46:31];
                state_next = S_POLY3;
            end
            S_POLY3:
            begin
                e_next     = e33[31:0];
                iter_next  = 5'(SQ_STEPS);
                state_next = S_SQ;
            end
            S_SQ:
            begin
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                e_next    = sq63[62:31];
                iter_next = iter_reg - 5'd1;
                state_next = (iter_reg == 5'd1) ? S_ALPHA : S_SQ;
            end
            S_ALPHA:
            begin
                alpha_next = (a18 > 18'd65536) ? 17'h10000 : a18[16:0];
                state_next = S_UPD_MUL;
            end
            S_UPD_MUL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                smooth_next = smooth_reg + upd[31:0];
                latest_next = smooth_reg + upd[31:0];
                state_next  = S_IDLE;
            end
            S_TICK:
            begin
                res_scaled_next = 32'd0;
                res_age_next    = age[31] ? 32'd0 : age;
                if (!have_reg) begin
                    res_age_next    = 32'd0;
                    res_status_next = STAT_NO_DATA;
                    pass_run_next   = RW'(0);
                    state_next      = S_OUT;
                end else if (max_age_reg != 32'd0 && !age[31] && age > max_age_reg) begin
                    res_status_next = STAT_STALE;
                    pass_run_next   = RW'(0);
                    state_next      = S_OUT;
                end else if (latest_bad_reg) begin
                    res_status_next = STAT_FAIL;
                    pass_run_next   = RW'(0);
                    state_next      = S_OUT;
                end else begin
                    state_next = S_SCALE_MUL;
                end
            end
            S_SCALE_MUL:
            begin
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                scaled_next = (mul_reg + SC_RND) >>> (FRAC + 8);
                state_next  = S_SCALE_CMP;
            end
            S_SCALE_CMP:
            begin
                if (scaled_reg >= lo_v && scaled_reg <= hi_v) begin
                    res_status_next = STAT_PASS;
                    if (pass_run_reg < RW'(RUN_MAX)) begin
                        pass_run_next = pass_run_reg + RW'(1);
                    end
                end else begin
                    res_status_next = STAT_FAIL;
                    pass_run_next   = RW'(0);
                end
                if (scaled_reg > SAT_HI) begin
                    res_scaled_next = 32'h7FFFFFFF;
                end else if (scaled_reg < SAT_LO) begin
                    res_scaled_next = 32'h80000000;
                end else begin
                    res_scaled_next = scaled_reg[31:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next   = 1'b1;
                    out_pressed_next = (32'(pass_run_reg) >= 32'(req_eff));
                    out_status_next  = res_status_reg;
                    out_run_next     = (32'(pass_run_reg) > 32'd255) ? 8'hFF
                                                                     : 8'(pass_run_reg);
                    out_scaled_next  = res_scaled_reg;
                    out_age_next     = res_age_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            fill_reg         <= '0;
            oldest_reg       <= '0;
            rd_ptr_reg       <= '0;
            sort_cnt_reg     <= '0;
            smooth_reg       <= '0;
            started_reg      <= 1'b0;
            last_stamp_reg   <= '0;
            latest_reg       <= '0;
            latest_bad_reg   <= 1'b0;
            latest_stamp_reg <= '0;
            have_reg         <= 1'b0;
            pass_run_reg     <= '0;
            filter_on_reg    <= 1'b1;
            window_len_reg   <= RST_WINDOW_LEN;
            tau_reg          <= RST_EMA_TAU;
            scale_reg        <= RST_SCALE;
            target_reg       <= '0;
            tol_reg          <= '0;
            req_reg          <= RST_REQ_RUN;
            max_age_reg      <= RST_MAX_AGE;
            iter_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            oldest_reg       <= oldest_next;
            rd_ptr_reg       <= rd_ptr_next;
            sort_cnt_reg     <= sort_cnt_next;
            smooth_reg       <= smooth_next;
            started_reg      <= started_next;
            last_stamp_reg   <= last_stamp_next;
            latest_reg       <= latest_next;
            latest_bad_reg   <= latest_bad_next;
            latest_stamp_reg <= latest_stamp_next;
            have_reg         <= have_next;
            pass_run_reg     <= pass_run_next;
            filter_on_reg    <= filter_on_next;
            window_len_reg   <= window_len_next;
            tau_reg          <= tau_next;
            scale_reg        <= scale_next;
            target_reg       <= target_next;
            tol_reg          <= tol_next;
            req_reg          <= req_next;
            max_age_reg      <= max_age_next;
            iter_reg         <= iter_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg         <= win_next;
        sorted_reg      <= sorted_next;
        samp_reg        <= samp_next;
        stamp_reg       <= stamp_next;
        med_a_reg       <= med_a_next;
        med_reg         <= med_next;
        rem_reg         <= rem_next;
        dbits_reg       <= dbits_next;
        q_reg           <= q_next;
        y2_reg          <= y2_next;
        e_reg           <= e_next;
        alpha_reg       <= alpha_next;
        mul_reg         <= mul_next;
        scaled_reg      <= scaled_next;
        res_status_reg  <= res_status_next;
        res_scaled_reg  <= res_scaled_next;
        res_age_reg     <= res_age_next;
        out_pressed_reg <= out_pressed_next;
        out_status_reg  <= out_status_next;
        out_run_reg     <= out_run_next;
        out_scaled_reg  <= out_scaled_next;
        out_age_reg     <= out_age_next;
    end

    `ASSERT_NXT(a_bad_sample_marks, clk, rst_n, in_acc && !s_axis_tuser[0] && s_axis_tuser[1], latest_bad_reg)
    `ASSERT_NXT(a_tick_busy, clk, rst_n, in_acc && s_axis_tuser[0], !s_axis_tready)
    `ASSERT_IMP(a_pass_has_run, clk, rst_n, m_axis_tvalid && m_axis_tuser[2:1] == STAT_PASS, m_axis_tdata[7:0] != 8'd0)
    `ASSERT_IMP(a_load_in_fill, clk, rst_n, state_reg == S_LOAD, sort_cnt_reg < fill_reg)

endmodule
